// ----- src/angular_blip_track_table_top_defines.svh -----
// Assertion macros shared by the checker.
`ifndef ANGULAR_BLIP_TRACK_TABLE_TOP_DEFINES_SVH
`define ANGULAR_BLIP_TRACK_TABLE_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ABT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication checked outside reset.
`define ABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- src/abtt_pkg.sv -----
package abtt_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int AngW = 15;
	localparam int LifeW = 13;
	localparam int Turn = 23040;
	localparam int HalfTurn = 11520;
	localparam int LifeOne = 4096;

	typedef enum logic [2:0] {
		OP_AUDIO = 3'd0,
		OP_DECAY = 3'd1,
		OP_SETGEN = 3'd2,
		OP_CLEAR = 3'd3,
		OP_READ = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_MERGED = 3'd1,
		ST_EVICTED = 3'd2,
		ST_STALE = 3'd3,
		ST_HIDDEN = 3'd4,
		ST_DONE = 3'd5
	} status_t;

	localparam logic [1:0] REG_DECAY = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;
	localparam logic [1:0] REG_VISIBLE = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture item
		logic prep;       // compute wrapped angle and life
		logic gen_update; // take new generation
		logic clr;        // empty table
		logic rd_en;      // read entry at scan index
		logic rd_first;   // reset scan and write indices
		logic wr_en;      // write entry (address by wr_sel_new / wr_life_max, else write index)
		logic wr_sel_new; // write the new sample (else max-life, moved or decayed entry)
		logic wr_life_max;// write max(old, new) life at the entry just read
		logic wr_idx_inc; // advance write index
		logic cnt_from_wr;// entry count takes write index
		logic cnt_inc;
		logic cnt_dec;
		logic out_status;
		logic out_entry;
		logic out_last;
		status_t st;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t op;
		logic visible;
		logic stale;
		logic newer;
		logic scan_end;   // scan index reached entry count
		logic match;      // entry just read is within the window
		logic keep;       // entry just read survives decay
		logic full;
		logic empty;
		logic last_entry; // entry just read is the final one
		logic first_read; // entry just read is entry 0
	} stat_t;
endpackage

// ----- src/abtt_ram.sv -----
module abtt_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/abtt_datapath.sv -----
module abtt_datapath import abtt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data,
	input logic [2:0] operation,
	input logic [31:0] session_generation,
	input logic signed [15:0] direction,
	input logic [12:0] loudness,
	input cmd_t cmd,
	output stat_t stat,
	output logic strobe,
	output logic kind,
	output logic [2:0] status,
	output logic signed [14:0] entry_angle,
	output logic [12:0] entry_life,
	output logic [6:0] occupancy,
	output logic last
);
	logic [12:0] decay_q;
	logic [13:0] window_q;
	logic [7:0] gain_q;
	logic visible_q;
	logic [31:0] gen_q, cur_gen_q;
	logic [2:0] op_q;
	logic signed [15:0] dir_q;
	logic [12:0] loud_q;
	logic signed [14:0] ang_q;
	logic [LifeW-1:0] life_q;
	logic [CntW-1:0] count_q, scan_q, wr_q;
	logic [CntW-1:0] rd_pos_q;

	logic signed [AngW-1:0] ram_ang;
	logic [LifeW-1:0] ram_life;
	logic [AngW-1:0] w_ang;
	logic [LifeW-1:0] w_life;
	logic [IdxW-1:0] w_addr;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= 13'd164;
			window_q <= 14'd1280;
			gain_q <= 8'd80;
			visible_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY: decay_q <= cfg_data[12:0];
				REG_WINDOW: window_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data[7:0];
				REG_VISIBLE: visible_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// angle wrap: |dir| < 2 turns, so at most one turn off
	logic signed [16:0] d_ext, r1, r2;
	always_comb begin
		d_ext = 17'(dir_q);
		if (d_ext >= 17'sd23040) r1 = d_ext - 17'sd23040;
		else if (d_ext <= -17'sd23040) r1 = d_ext + 17'sd23040;
		else r1 = d_ext;
		if (r1 < -17'sd11520) r2 = r1 + 17'sd23040;
		else if (r1 > 17'sd11520) r2 = r1 - 17'sd23040;
		else r2 = r1;
	end

	logic [12:0] l_clamp;
	logic [20:0] prod;
	logic [16:0] life_raw;
	assign l_clamp = (loud_q > 13'd4096) ? 13'd4096 : loud_q;
	assign prod = 21'(l_clamp) * 21'(gain_q);
	assign life_raw = prod[20:4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			gen_q <= session_generation;
			dir_q <= direction;
			loud_q <= loudness;
		end
		if (cmd.prep) begin
			ang_q <= r2[14:0];
			life_q <= (life_raw > 17'd4096) ? 13'd4096 : life_raw[12:0];
		end
	end

	// circular distance of entry vs sample
	logic signed [15:0] diff;
	logic [15:0] adiff, cdist;
	always_comb begin
		diff = 16'(ram_ang) - 16'(ang_q);
		adiff = diff[15] ? 16'(-diff) : 16'(diff);
		cdist = (adiff > 16'd11520) ? 16'd23040 - adiff : adiff;
	end

	logic [13:0] decayed;
	assign decayed = 14'(ram_life) - 14'(decay_q);

	// scan, write, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_gen_q <= '0;
			scan_q <= '0;
			wr_q <= '0;
			rd_pos_q <= '0;
		end else begin
			if (cmd.gen_update) cur_gen_q <= gen_q;
			if (cmd.rd_en) rd_pos_q <= scan_q;
			if (cmd.rd_first) begin
				scan_q <= '0;
				wr_q <= '0;
			end else if (cmd.rd_en) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.wr_idx_inc) wr_q <= wr_q + 1'b1;
			if (cmd.clr) count_q <= '0;
			else if (cmd.cnt_from_wr) count_q <= wr_q;
			else if (cmd.cnt_inc) count_q <= count_q + 1'b1;
			else if (cmd.cnt_dec) count_q <= count_q - 1'b1;
		end
	end

	always_comb begin
		if (cmd.wr_sel_new) begin
			w_ang = ang_q;
			w_life = life_q;
			w_addr = count_q[IdxW-1:0];
		end else if (cmd.wr_life_max) begin
			w_ang = ram_ang;
			w_life = (life_q > ram_life) ? life_q : ram_life;
			w_addr = rd_pos_q[IdxW-1:0];
		end else begin
			// move (eviction shift) or decay compaction
			w_ang = ram_ang;
			w_life = (op_q == OP_DECAY) ? decayed[LifeW-1:0] : ram_life;
			w_addr = wr_q[IdxW-1:0];
		end
	end

	abtt_ram #(.Width(AngW), .Depth(TableDepth)) u_ang (
		.clk(clk), .we(cmd.wr_en), .waddr(w_addr), .wdata(w_ang),
		.raddr(scan_q[IdxW-1:0]), .rdata(ram_ang));
	abtt_ram #(.Width(LifeW), .Depth(TableDepth)) u_life (
		.clk(clk), .we(cmd.wr_en), .waddr(w_addr), .wdata(w_life),
		.raddr(scan_q[IdxW-1:0]), .rdata(ram_life));

	always_comb begin
		stat.op = op_t'(op_q);
		stat.visible = visible_q;
		stat.stale = gen_q < cur_gen_q;
		stat.newer = gen_q > cur_gen_q;
		stat.scan_end = scan_q >= count_q;
		stat.match = cdist < 16'(window_q);
		stat.keep = !decayed[13] && (decayed != 14'd0);
		stat.full = count_q >= CntW'(TableDepth);
		stat.empty = count_q == '0;
		stat.last_entry = (rd_pos_q + 1'b1) == count_q;
		stat.first_read = rd_pos_q == '0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.out_status | cmd.out_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_entry) begin
			kind <= 1'b1;
			status <= ST_DONE;
			entry_angle <= ram_ang;
			entry_life <= ram_life;
		end else begin
			kind <= 1'b0;
			status <= cmd.st;
			entry_angle <= '0;
			entry_life <= '0;
		end
		occupancy <= 7'(count_q);
		last <= cmd.out_last;
	end
endmodule

// ----- src/abtt_ctrl.sv -----
module abtt_ctrl import abtt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input stat_t stat,
	output logic busy,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DISPATCH, S_MSCAN, S_MTEST, S_APPEND,
		S_SHIFT, S_SHIFT_W, S_DSCAN, S_DTEST, S_DFIN, S_RSCAN, S_ROUT, S_DONE
	} state_t;

	state_t state_q;
	status_t st_q;

	always_comb begin
		cmd = '0;
		cmd.st = st_q;
		cmd.load = (state_q == S_IDLE) && start;
		unique case (state_q)
			S_IDLE: ;
			S_PREP: cmd.prep = 1'b1;
			S_DISPATCH: begin
				cmd.rd_first = 1'b1;
				if (stat.op == OP_AUDIO && stat.visible && stat.newer) begin
					cmd.gen_update = 1'b1;
					cmd.clr = 1'b1;
				end else if (stat.op == OP_SETGEN) begin
					cmd.gen_update = 1'b1;
					cmd.clr = 1'b1;
				end else if (stat.op == OP_CLEAR) begin
					cmd.clr = 1'b1;
				end
			end
			S_MSCAN: begin
				cmd.rd_en = !stat.scan_end;
				// restart the scan for the eviction shift
				cmd.rd_first = stat.scan_end && stat.full;
			end
			S_MTEST: begin
				// raise the life of the entry just read on a match
				cmd.wr_en = stat.match;
				cmd.wr_life_max = stat.match;
			end
			S_APPEND: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel_new = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_SHIFT: begin
				cmd.rd_en = !stat.scan_end;
				cmd.cnt_dec = stat.scan_end;
			end
			S_SHIFT_W: begin
				cmd.wr_en = !stat.first_read;
				cmd.wr_idx_inc = !stat.first_read;
			end
			S_DSCAN: cmd.rd_en = !stat.scan_end;
			S_DTEST: begin
				cmd.wr_en = stat.keep;
				cmd.wr_idx_inc = stat.keep;
			end
			S_DFIN: cmd.cnt_from_wr = 1'b1;
			S_RSCAN: cmd.rd_en = !stat.scan_end;
			S_ROUT: begin
				cmd.out_entry = 1'b1;
				cmd.out_last = stat.last_entry;
			end
			S_DONE: begin
				cmd.out_status = 1'b1;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_PREP;
					st_q <= ST_DONE;
				end
				S_PREP: state_q <= S_DISPATCH;
				S_DISPATCH: begin
					priority case (stat.op)
						OP_AUDIO: begin
							if (!stat.visible) begin
								st_q <= ST_HIDDEN;
								state_q <= S_DONE;
							end else if (stat.stale) begin
								st_q <= ST_STALE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_MSCAN;
							end
						end
						OP_DECAY: state_q <= S_DSCAN;
						OP_READ: begin
							if (stat.empty) state_q <= S_DONE;
							else state_q <= S_RSCAN;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_MSCAN: begin
					if (stat.scan_end) begin
						if (stat.full) begin
							st_q <= ST_EVICTED;
							state_q <= S_SHIFT;
						end else begin
							st_q <= ST_INSERTED;
							state_q <= S_APPEND;
						end
					end else begin
						state_q <= S_MTEST;
					end
				end
				S_MTEST: begin
					if (stat.match) begin
						st_q <= ST_MERGED;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MSCAN;
					end
				end
				S_APPEND: state_q <= S_DONE;
				S_SHIFT: begin
					// first read is entry 0, dropped; others move down one
					if (stat.scan_end) state_q <= S_APPEND;
					else state_q <= S_SHIFT_W;
				end
				S_SHIFT_W: state_q <= S_SHIFT;
				S_DSCAN: state_q <= stat.scan_end ? S_DFIN : S_DTEST;
				S_DTEST: state_q <= S_DSCAN;
				S_DFIN: state_q <= S_DONE;
				S_RSCAN: state_q <= S_ROUT;
				S_ROUT: state_q <= stat.last_entry ? S_IDLE : S_RSCAN;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/angular_blip_track_table_top.sv -----
// Angular blip track table.
// Pulse start with operation, session_generation, direction and loudness
// while busy is low; the item is taken at that edge and busy rises.
// Results come out one per strobe cycle on kind, status, entry_angle,
// entry_life, occupancy and last; the receiver cannot hold them off.
// Configuration: cfg_we with cfg_index (0 decay_step, 1 merge_window,
// 2 visual_gain, 3 overlay_visible) and cfg_data; the user must write these
// only while idle; the block itself does not enforce it. Control items
// answer with one status result; an audio item scans the table until a
// match, and a full-table eviction then shifts every entry down one; a
// decay tick scans every entry; a read out emits one entry per strobe.
// Each table scan reads the registered-read RAMs in the controller loop;
// the longest item is an audio item evicting from a full table.
// Reset empties the table, zeroes the generation and loads register
// defaults; table contents are undefined until written.
module angular_blip_track_table_top import abtt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] operation,
	input logic [31:0] session_generation,
	input logic signed [15:0] direction,
	input logic [12:0] loudness,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data,
	output logic strobe,
	output logic kind,
	output logic [2:0] status,
	output logic signed [14:0] entry_angle,
	output logic [12:0] entry_life,
	output logic [6:0] occupancy,
	output logic last
);
	cmd_t cmd;
	stat_t stat;

	abtt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.busy(busy), .cmd(cmd));

	abtt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .operation(operation),
		.session_generation(session_generation), .direction(direction),
		.loudness(loudness), .cmd(cmd), .stat(stat), .strobe(strobe),
		.kind(kind), .status(status), .entry_angle(entry_angle),
		.entry_life(entry_life), .occupancy(occupancy), .last(last));
endmodule

// ----- src/abtt_checker.sv -----
`include "angular_blip_track_table_top_defines.svh"
module abtt_checker import abtt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic kind,
	input logic [2:0] status,
	input logic [6:0] occupancy,
	input logic last
);
	`ABT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "busy did not rise")
	`ABT_ASSERT_IMPL(a_strobe_busy, clk, arst_n, strobe && !last, busy, "idle mid-result")
	`ABT_ASSERT_IMPL(a_entry_done, clk, arst_n, strobe && kind, status == ST_DONE, "entry status")
	`ABT_ASSERT_IMPL(a_occ_range, clk, arst_n, strobe, occupancy <= 7'(TableDepth), "occupancy")
endmodule

bind angular_blip_track_table_top abtt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.kind(kind), .status(status), .occupancy(occupancy), .last(last));

// ----- tb/sv/angular_blip_track_table_top_tb.sv -----
`timescale 1ns / 100ps

module angular_blip_track_table_top_tb;
	import abtt_pkg::*;

	typedef struct {
		logic kind;
		logic [2:0] st;
		logic signed [14:0] angle;
		logic [12:0] life;
		logic [6:0] occ;
		logic last;
	} blip_result_t;

	class blip_scoreboard;
		int angle_tab[TableDepth];
		int life_tab[TableDepth];
		int count;
		bit [31:0] cur_gen;
		int decay_step, merge_window, visual_gain, visible;
		blip_result_t pending_q[$];
		int errors;

		function new();
			count = 0;
			cur_gen = 0;
			decay_step = 164;
			merge_window = 1280;
			visual_gain = 80;
			visible = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, int val);
			case (idx)
				REG_DECAY: decay_step = val & 'h1FFF;
				REG_WINDOW: merge_window = val & 'h3FFF;
				REG_GAIN: visual_gain = val & 'hFF;
				REG_VISIBLE: visible = val & 1;
				default: ;
			endcase
		endfunction

		function void push(logic kind, status_t st, int angle, int life, logic last);
			blip_result_t r;
			r.kind = kind;
			r.st = st;
			r.angle = angle[14:0];
			r.life = life[12:0];
			r.occ = count[6:0];
			r.last = last;
			pending_q.insert(pending_q.size(), r);
		endfunction

		function status_t place_sample(bit [31:0] gen, logic signed [15:0] dir, int loud);
			int a, lv, dd, i;
			a = int'(dir) % Turn;
			if (a < -HalfTurn) a += Turn;
			if (a > HalfTurn) a -= Turn;
			if (loud > LifeOne) loud = LifeOne;
			lv = (loud * visual_gain) >> 4;
			if (lv > LifeOne) lv = LifeOne;
			if (visible == 0) return ST_HIDDEN;
			if (gen < cur_gen) return ST_STALE;
			if (gen > cur_gen) begin
				cur_gen = gen;
				count = 0;
			end
			for (i = 0; i < count; i++) begin
				dd = angle_tab[i] - a;
				if (dd < 0) dd = -dd;
				dd = dd % Turn;
				if (dd > HalfTurn) dd = Turn - dd;
				if (dd < merge_window) begin
					if (lv > life_tab[i]) life_tab[i] = lv;
					return ST_MERGED;
				end
			end
			if (count >= TableDepth) begin
				for (i = 0; i < TableDepth - 1; i++) begin
					angle_tab[i] = angle_tab[i + 1];
					life_tab[i] = life_tab[i + 1];
				end
				angle_tab[TableDepth - 1] = a;
				life_tab[TableDepth - 1] = lv;
				return ST_EVICTED;
			end
			angle_tab[count] = a;
			life_tab[count] = lv;
			count++;
			return ST_INSERTED;
		endfunction

		function void note_item(logic [2:0] op, bit [31:0] gen, logic signed [15:0] dir,
				int loud);
			status_t st;
			int i, kept, nl;
			st = ST_DONE;
			case (op)
				OP_AUDIO: st = place_sample(gen, dir, loud);
				OP_DECAY: begin
					kept = 0;
					for (i = 0; i < count; i++) begin
						nl = life_tab[i] - decay_step;
						if (nl > 0) begin
							angle_tab[kept] = angle_tab[i];
							life_tab[kept] = nl;
							kept++;
						end
					end
					count = kept;
				end
				OP_SETGEN: begin
					cur_gen = gen;
					count = 0;
				end
				OP_CLEAR: count = 0;
				OP_READ: begin
					for (i = 0; i < count; i++)
						push(1'b1, ST_DONE, angle_tab[i], life_tab[i], i + 1 == count);
					if (count > 0) return;
				end
				default: ;
			endcase
			push(1'b0, st, 0, 0, 1'b1);
		endfunction

		function void check_result(logic kind, logic [2:0] st, logic signed [14:0] angle,
				logic [12:0] life, logic [6:0] occ, logic last);
			blip_result_t e;
			if (pending_q.size() == 0) begin
				$display("%0t ERROR: unexpected result kind %0d status %0d", $time, kind, st);
				errors++;
				return;
			end
			e = pending_q[0];
			pending_q.delete(0);
			if (e.kind !== kind) begin
				$display("%0t ERROR: kind exp %0d got %0d", $time, e.kind, kind);
				errors++;
			end
			if (e.st !== st) begin
				$display("%0t ERROR: status exp %0d got %0d", $time, e.st, st);
				errors++;
			end
			if (e.angle !== angle) begin
				$display("%0t ERROR: entry_angle exp %0d got %0d", $time, e.angle, angle);
				errors++;
			end
			if (e.life !== life) begin
				$display("%0t ERROR: entry_life exp %0d got %0d", $time, e.life, life);
				errors++;
			end
			if (e.occ !== occ) begin
				$display("%0t ERROR: occupancy exp %0d got %0d", $time, e.occ, occ);
				errors++;
			end
			if (e.last !== last) begin
				$display("%0t ERROR: last exp %0d got %0d", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] operation = '0;
	logic [31:0] session_generation = '0;
	logic signed [15:0] direction = '0;
	logic [12:0] loudness = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;
	logic strobe;
	logic kind;
	logic [2:0] status;
	logic signed [14:0] entry_angle;
	logic [12:0] entry_life;
	logic [6:0] occupancy;
	logic last;

	localparam int IdleLimit = 4000;
	localparam int SettleCycles = 200;

	blip_scoreboard blip_sb;
	int idle_cycles = 0;

	angular_blip_track_table_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.session_generation(session_generation),
		.direction(direction),
		.loudness(loudness),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.kind(kind),
		.status(status),
		.entry_angle(entry_angle),
		.entry_life(entry_life),
		.occupancy(occupancy),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			blip_sb.check_result(kind, status, entry_angle, entry_life, occupancy, last);
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("angular_blip_track_table_top: mismatch");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] op, logic [31:0] gen, logic [15:0] dir,
			logic [12:0] loud);
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		session_generation <= gen;
		direction <= dir;
		loudness <= loud;
		@(posedge clk);
		while (busy) @(posedge clk);
		blip_sb.note_item(op, gen, dir, loud);
	endtask

	// hold off until every expected result is in
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (blip_sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// write only with the block idle
	task automatic write_reg(logic [1:0] idx, int val);
		drain();
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[13:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		blip_sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_regs(int decay, int window, int gain, int vis);
		write_reg(REG_DECAY, decay);
		write_reg(REG_WINDOW, window);
		write_reg(REG_GAIN, gain);
		write_reg(REG_VISIBLE, vis);
	endtask

	task automatic random_items(int n);
		int i, r;
		logic [2:0] op;
		logic [31:0] gen;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) op = OP_AUDIO;
			else if (r < 72) op = OP_DECAY;
			else if (r < 84) op = OP_READ;
			else if (r < 91) op = OP_SETGEN;
			else if (r < 96) op = OP_CLEAR;
			else op = 3'($urandom_range(5, 7));
			r = $urandom_range(0, 99);
			if (op == OP_SETGEN)
				gen = (r < 85) ? 32'($urandom_range(0, 1000)) : $urandom;
			else if (r < 80) gen = blip_sb.cur_gen;
			else if (r < 90) gen = blip_sb.cur_gen + 1;
			else if (r < 96) gen = blip_sb.cur_gen - 1;
			else gen = $urandom;
			send_item(op, gen, 16'($urandom_range(0, 65535)),
				($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
				: 13'($urandom_range(0, 4096)));
			if ($urandom_range(0, 19) == 0) drain();
		end
	endtask

	initial begin
		int i;
		blip_sb = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_AUDIO, 0, 0, 2048);
		write_reg(REG_VISIBLE, 1);
		send_item(OP_SETGEN, 5, 0, 0);
		send_item(OP_AUDIO, 3, 0, 1000);
		send_item(OP_AUDIO, 5, 16'sd23039, 13'd8191);
		send_item(OP_AUDIO, 5, -16'sd23039, 13'd1000);
		send_item(OP_AUDIO, 5, 16'sd11520, 13'd0);
		send_item(OP_AUDIO, 5, -16'sd11521, 13'd4096);
		send_item(OP_AUDIO, 5, 16'h8000, 13'd300);
		send_item(OP_AUDIO, 5, 16'h7FFF, 13'd40);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_DECAY, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_AUDIO, 6, 100, 1);
		send_item(OP_CLEAR, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0);
		send_item(3'd5, 0, 0, 0);
		send_item(3'd6, 0, 0, 0);
		send_item(3'd7, 0, 0, 0);
		send_item(OP_SETGEN, 32'hFFFFFFFF, 0, 0);
		send_item(OP_AUDIO, 32'hFFFFFFFF, 0, 4096);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_SETGEN, 0, 0, 0);

		random_items(8);
		set_regs(4096, 11520, 255, 1);
		random_items(6);
		set_regs(0, 0, 0, 1);
		random_items(6);
		write_reg(REG_VISIBLE, 0);
		random_items(3);

		// fill past depth to force evictions
		set_regs(1, 0, 255, 1);
		send_item(OP_SETGEN, 1, 0, 0);
		for (i = 0; i < TableDepth + 6; i++)
			send_item(OP_AUDIO, 1, 16'($urandom_range(0, 65535)),
				13'($urandom_range(0, 4096)));
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_DECAY, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0);
		set_regs(164, 1280, 80, 1);
		random_items(5);

		drain();
		repeat (SettleCycles) @(posedge clk);
		if (blip_sb.errors == 0 && blip_sb.pending_q.size() == 0)
			$display("angular_blip_track_table_top: match");
		else
			$display("angular_blip_track_table_top: mismatch");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+src
src/abtt_pkg.sv
src/abtt_ram.sv
src/abtt_datapath.sv
src/abtt_ctrl.sv
src/angular_blip_track_table_top.sv
src/abtt_checker.sv
tb/sv/angular_blip_track_table_top_tb.sv
